// ===== rtl/ecb_pkg.sv =====
// Shared types and constants of the execution coverage bitmap.
`default_nettype none

package ecb_pkg;

    typedef enum logic [2:0] {
        FN_RECORD = 3'd0,
        FN_TEST   = 3'd1,
        FN_COUNT  = 3'd2,
        FN_RUNS   = 3'd3,
        FN_GAPS   = 3'd4,
        FN_CLEAR  = 3'd5
    } func_t;

    localparam int unsigned CFG_WIDTH   = 7;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned ROW_BITS    = 8;
    localparam int unsigned ROW_SEL_W   = 3;
    localparam logic [CFG_WIDTH-1:0] MAX_RUNS_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_REC_EN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RUNS = 1'b1;

    typedef enum logic [1:0] {
        EMIT_NONE  = 2'd0,
        EMIT_PLAIN = 2'd1,
        EMIT_TEST  = 2'd2,
        EMIT_COUNT = 2'd3
    } emit_t;

    typedef struct packed {
        logic  load;
        logic  sel_in;
        logic  rec;
        logic  clr_row;
        logic  ctr_clr;
        logic  scan_init;
        logic  issue;
        logic  step;
        logic  tail;
        logic  list_rd;
        emit_t emit;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic empty;
        logic stop;
        logic is_list;
        logic list_empty;
        logic list_final;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/execution_coverage_bitmap_top.sv =====
// Top level of the execution coverage bitmap: sequencer, datapath and checks.
`default_nettype none

// Command port: a transaction is taken at a rising edge with start high and busy low.
// Config writes (wr_en, wr_index, wr_data) land at once; write them only while idle.
// Each result shows on the outputs for one cycle with done high; last marks the final one.
// The receiver cannot stall; results are never held back.
// How each transaction proceeds:
//   record: map read, then write; test: map read only.
//   unused codes: answered straight from idle, back to back.
//   clear: one map row cleared per cycle.
//   count: the scan reads one map bit per cycle.
//   run and gap listing: a scan, then one item per cycle;
//   an empty listing answers after the scan.
//   count or gap listing of an empty range (start above end): answered without a scan.
//   Run listing scans all 2^ADDR_BITS addresses; a listing stops early at the limit.
// Reset: a clearing pass over all 2^(ADDR_BITS-3) map rows (8192 by default) runs with
// busy high; the instruction count is zero, recording off, limit at 64.
module execution_coverage_bitmap_top #(
    parameter int unsigned ADDR_BITS      = 16,
    parameter int unsigned MAX_RUNS_LIMIT = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [2:0]                    func,
    input  wire logic [ADDR_BITS-1:0]          address,
    input  wire logic [ADDR_BITS-1:0]          range_end,
    input  wire logic                          wr_en,
    input  wire logic [ecb_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [ecb_pkg::CFG_WIDTH-1:0] wr_data,
    output logic                               done,
    output logic                               executed,
    output logic [ADDR_BITS:0]                 hit_count,
    output logic [ADDR_BITS-1:0]               run_start,
    output logic [ADDR_BITS-1:0]               run_end,
    output logic                               run_valid,
    output logic                               truncated,
    output logic [31:0]                        instruction_total,
    output logic                               last
);

    ecb_pkg::cmd_t    cmd;
    ecb_pkg::status_t status;

    ecb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    ecb_dp #(
        .ADDR_BITS      (ADDR_BITS),
        .MAX_RUNS_LIMIT (MAX_RUNS_LIMIT)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .func              (func),
        .address           (address),
        .range_end         (range_end),
        .wr_en             (wr_en),
        .wr_index          (wr_index),
        .wr_data           (wr_data),
        .done              (done),
        .executed          (executed),
        .hit_count         (hit_count),
        .run_start         (run_start),
        .run_end           (run_end),
        .run_valid         (run_valid),
        .truncated         (truncated),
        .instruction_total (instruction_total),
        .last              (last)
    );

    a_list_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |=> done)
        else $error("listing items not contiguous");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted transaction produced no work");

    a_empty_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        done && !run_valid |-> run_start == '0 && run_end == '0 && !truncated)
        else $error("empty item carries bounds or truncation");

    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        done && run_valid |-> run_start <= run_end)
        else $error("run bounds out of order");

endmodule

`default_nettype wire

// ===== rtl/ecb_ctrl.sv =====
// Sequencer of the execution coverage bitmap.
`default_nettype none

module ecb_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [2:0]      func,
    input  wire ecb_pkg::status_t status,
    output ecb_pkg::cmd_t        cmd,
    output logic                 busy
);

    typedef enum logic [11:0] {
        S_INIT  = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_REC   = 12'b0000_0000_0100,
        S_TEST  = 12'b0000_0000_1000,
        S_CLR   = 12'b0000_0001_0000,
        S_SETUP = 12'b0000_0010_0000,
        S_PRIME = 12'b0000_0100_0000,
        S_SCAN  = 12'b0000_1000_0000,
        S_FIN   = 12'b0001_0000_0000,
        S_TAIL  = 12'b0010_0000_0000,
        S_LIST  = 12'b0100_0000_0000,
        S_DRAIN = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit   = ecb_pkg::EMIT_NONE;
        cmd.sel_in = (state_reg == S_IDLE);
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_row = 1'b1;
                if (status.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (func)
                        ecb_pkg::FN_RECORD: state_next = S_REC;
                        ecb_pkg::FN_TEST:   state_next = S_TEST;
                        ecb_pkg::FN_CLEAR:  state_next = S_CLR;
                        ecb_pkg::FN_COUNT,
                        ecb_pkg::FN_RUNS,
                        ecb_pkg::FN_GAPS:   state_next = S_SETUP;
                        default:            cmd.emit = ecb_pkg::EMIT_PLAIN;
                    endcase
                end
            end
            S_REC:
            begin
                cmd.rec    = 1'b1;
                cmd.emit   = ecb_pkg::EMIT_PLAIN;
                state_next = S_IDLE;
            end
            S_TEST:
            begin
                cmd.emit   = ecb_pkg::EMIT_TEST;
                state_next = S_IDLE;
            end
            S_CLR:
            begin
                cmd.clr_row = 1'b1;
                cmd.ctr_clr = 1'b1;
                if (status.clr_done)
                begin
                    cmd.emit   = ecb_pkg::EMIT_PLAIN;
                    state_next = S_IDLE;
                end
            end
            S_SETUP:
            begin
                cmd.scan_init = 1'b1;
                if (status.empty)
                begin
                    cmd.emit   = ecb_pkg::EMIT_PLAIN;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_PRIME;
                end
            end
            S_PRIME:
            begin
                cmd.issue  = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
                cmd.step  = 1'b1;
                if (status.stop)
                begin
                    state_next = status.is_list ? S_TAIL : S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.emit   = ecb_pkg::EMIT_COUNT;
                state_next = S_IDLE;
            end
            S_TAIL:
            begin
                cmd.tail   = 1'b1;
                state_next = S_LIST;
            end
            S_LIST:
            begin
                if (status.list_empty)
                begin
                    cmd.emit   = ecb_pkg::EMIT_PLAIN;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.list_rd = 1'b1;
                    if (status.list_final)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/ecb_dp.sv =====
// Datapath: coverage map, run list, counters, configuration and result registers.
`default_nettype none

module ecb_dp #(
    parameter int unsigned ADDR_BITS      = 16,
    parameter int unsigned MAX_RUNS_LIMIT = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ecb_pkg::cmd_t                       cmd,
    output ecb_pkg::status_t                         status,
    input  wire logic [2:0]                          func,
    input  wire logic [ADDR_BITS-1:0]                address,
    input  wire logic [ADDR_BITS-1:0]                range_end,
    input  wire logic                                wr_en,
    input  wire logic [ecb_pkg::CFG_IDX_W-1:0]       wr_index,
    input  wire logic [ecb_pkg::CFG_WIDTH-1:0]       wr_data,
    output logic                                     done,
    output logic                                     executed,
    output logic [ADDR_BITS:0]                       hit_count,
    output logic [ADDR_BITS-1:0]                     run_start,
    output logic [ADDR_BITS-1:0]                     run_end,
    output logic                                     run_valid,
    output logic                                     truncated,
    output logic [31:0]                              instruction_total,
    output logic                                     last
);

    localparam int unsigned ROW_AW  = ADDR_BITS - ecb_pkg::ROW_SEL_W;
    localparam int unsigned ROWS    = 1 << ROW_AW;
    localparam int unsigned LIST_AW = (MAX_RUNS_LIMIT > 1) ? $clog2(MAX_RUNS_LIMIT) : 1;
    localparam int unsigned NW      = $clog2(MAX_RUNS_LIMIT + 1);
    localparam int unsigned CW      = ecb_pkg::CFG_WIDTH;

    logic [ecb_pkg::ROW_BITS-1:0] map_mem [ROWS];
    logic [2*ADDR_BITS-1:0]       list_mem [MAX_RUNS_LIMIT];

    logic [ecb_pkg::ROW_BITS-1:0] rdata_reg;
    logic [2*ADDR_BITS-1:0]       lrd_reg;

    logic                 rec_en_reg;
    logic [CW-1:0]        max_runs_reg;
    logic [2:0]           func_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] rend_reg;
    logic [ADDR_BITS-1:0] ptr_reg;
    logic [ADDR_BITS-1:0] pa_reg;
    logic [ADDR_BITS-1:0] start_reg;
    logic [ADDR_BITS:0]   hits_reg;
    logic [NW-1:0]        n_reg;
    logic [NW-1:0]        k_reg;
    logic                 in_run_reg;
    logic                 more_reg;
    logic [ROW_AW-1:0]    clr_cnt_reg;
    logic [31:0]          ctr_reg;
    logic                 ev_reg;
    logic                 elast_reg;

    logic                 done_reg;
    logic                 executed_reg;
    logic [ADDR_BITS:0]   hit_count_reg;
    logic [ADDR_BITS-1:0] run_start_reg;
    logic [ADDR_BITS-1:0] run_end_reg;
    logic                 run_valid_reg;
    logic                 truncated_reg;
    logic                 last_reg;

    logic                 executed_next;
    logic [ADDR_BITS:0]   hit_count_next;
    logic [ADDR_BITS-1:0] run_start_next;
    logic [ADDR_BITS-1:0] run_end_next;
    logic                 run_valid_next;
    logic                 truncated_next;
    logic                 last_next;

    logic                 is_runs;
    logic                 is_list;
    logic [ADDR_BITS-1:0] lo_w;
    logic [ADDR_BITS-1:0] hi_w;
    logic [CW-1:0]        lim_w;
    logic                 room;
    logic                 bit_w;
    logic                 match;
    logic                 open_run;
    logic                 close_run;
    logic [ROW_AW-1:0]    rd_row;
    logic                 map_we;
    logic [ROW_AW-1:0]    map_wa;
    logic [ecb_pkg::ROW_BITS-1:0] map_wd;
    logic                 list_we;
    logic [2*ADDR_BITS-1:0] list_wd;

    assign is_runs = (func_reg == ecb_pkg::FN_RUNS);
    assign is_list = is_runs || (func_reg == ecb_pkg::FN_GAPS);
    assign lo_w    = is_runs ? '0 : addr_reg;
    assign hi_w    = is_runs ? '1 : rend_reg;
    assign lim_w   = (max_runs_reg == '0 || max_runs_reg > CW'(MAX_RUNS_LIMIT))
                     ? CW'(MAX_RUNS_LIMIT) : max_runs_reg;
    assign room    = 8'(n_reg) < 8'(lim_w);

    assign bit_w     = rdata_reg[pa_reg[ecb_pkg::ROW_SEL_W-1:0]];
    assign match     = (bit_w == is_runs);
    assign open_run  = is_list && match && !in_run_reg;
    assign close_run = is_list && !match && in_run_reg;

    assign rd_row = cmd.sel_in ? address[ADDR_BITS-1:ecb_pkg::ROW_SEL_W]
                               : ptr_reg[ADDR_BITS-1:ecb_pkg::ROW_SEL_W];

    always_comb
    begin
        map_we = 1'b0;
        map_wa = clr_cnt_reg;
        map_wd = '0;
        if (cmd.clr_row)
        begin
            map_we = 1'b1;
        end
        else if (cmd.rec && rec_en_reg)
        begin
            map_we = 1'b1;
            map_wa = addr_reg[ADDR_BITS-1:ecb_pkg::ROW_SEL_W];
            map_wd = rdata_reg | (8'b1 << addr_reg[ecb_pkg::ROW_SEL_W-1:0]);
        end
    end

    always_comb
    begin
        list_we = 1'b0;
        list_wd = {start_reg, hi_w};
        if (cmd.step && close_run && room)
        begin
            list_we = 1'b1;
            list_wd = {start_reg, ADDR_BITS'(pa_reg - 1'b1)};
        end
        else if (cmd.tail && in_run_reg && !more_reg && room)
        begin
            list_we = 1'b1;
        end
    end

    always_comb
    begin
        executed_next  = 1'b0;
        hit_count_next = '0;
        run_start_next = '0;
        run_end_next   = '0;
        run_valid_next = 1'b0;
        truncated_next = 1'b0;
        last_next      = 1'b1;
        if (ev_reg)
        begin
            run_start_next = lrd_reg[2*ADDR_BITS-1:ADDR_BITS];
            run_end_next   = lrd_reg[ADDR_BITS-1:0];
            run_valid_next = 1'b1;
            truncated_next = more_reg;
            last_next      = elast_reg;
        end
        else
        begin
            case (cmd.emit)
                ecb_pkg::EMIT_TEST:  executed_next  = rdata_reg[addr_reg[ecb_pkg::ROW_SEL_W-1:0]];
                ecb_pkg::EMIT_COUNT: hit_count_next = hits_reg;
                default:             executed_next  = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_wa] <= map_wd;
        end
        rdata_reg <= map_mem[rd_row];
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[n_reg[LIST_AW-1:0]] <= list_wd;
        end
        lrd_reg <= list_mem[k_reg[LIST_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_en_reg   <= 1'b0;
            max_runs_reg <= ecb_pkg::MAX_RUNS_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                ecb_pkg::REG_REC_EN:   rec_en_reg   <= wr_data[0];
                ecb_pkg::REG_MAX_RUNS: max_runs_reg <= wr_data;
                default:               rec_en_reg   <= rec_en_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            ctr_reg     <= '0;
            in_run_reg  <= 1'b0;
            more_reg    <= 1'b0;
            n_reg       <= '0;
            k_reg       <= '0;
            ev_reg      <= 1'b0;
            elast_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clr_row)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.ctr_clr)
            begin
                ctr_reg <= '0;
            end
            else if (cmd.rec && rec_en_reg)
            begin
                ctr_reg <= ctr_reg + 32'd1;
            end
            if (cmd.scan_init)
            begin
                in_run_reg <= 1'b0;
                more_reg   <= 1'b0;
                n_reg      <= '0;
                k_reg      <= '0;
            end
            else if (cmd.step)
            begin
                if (open_run)
                begin
                    in_run_reg <= 1'b1;
                end
                else if (close_run)
                begin
                    in_run_reg <= 1'b0;
                    if (room)
                    begin
                        n_reg <= n_reg + 1'b1;
                    end
                    else
                    begin
                        more_reg <= 1'b1;
                    end
                end
            end
            else if (cmd.tail && in_run_reg && !more_reg)
            begin
                if (room)
                begin
                    n_reg <= n_reg + 1'b1;
                end
                else
                begin
                    more_reg <= 1'b1;
                end
            end
            else if (cmd.list_rd)
            begin
                k_reg <= k_reg + 1'b1;
            end
            ev_reg    <= cmd.list_rd;
            elast_reg <= status.list_final;
            done_reg  <= (cmd.emit != ecb_pkg::EMIT_NONE) || ev_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            addr_reg <= address;
            rend_reg <= range_end;
        end
        if (cmd.scan_init)
        begin
            ptr_reg  <= lo_w;
            hits_reg <= '0;
        end
        else
        begin
            if (cmd.issue)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (cmd.step)
            begin
                hits_reg <= hits_reg + (ADDR_BITS+1)'(bit_w);
            end
        end
        if (cmd.issue)
        begin
            pa_reg <= ptr_reg;
        end
        if (cmd.step && open_run)
        begin
            start_reg <= pa_reg;
        end

        executed_reg  <= executed_next;
        hit_count_reg <= hit_count_next;
        run_start_reg <= run_start_next;
        run_end_reg   <= run_end_next;
        run_valid_reg <= run_valid_next;
        truncated_reg <= truncated_next;
        last_reg      <= last_next;
    end

    assign status.clr_done   = &clr_cnt_reg;
    assign status.empty      = !is_runs && (addr_reg > rend_reg);
    assign status.stop       = (pa_reg == hi_w) || (close_run && !room);
    assign status.is_list    = is_list;
    assign status.list_empty = (n_reg == '0);
    assign status.list_final = (NW'(k_reg + 1'b1) == n_reg);

    assign done              = done_reg;
    assign executed          = executed_reg;
    assign hit_count         = hit_count_reg;
    assign run_start         = run_start_reg;
    assign run_end           = run_end_reg;
    assign run_valid         = run_valid_reg;
    assign truncated         = truncated_reg;
    assign instruction_total = ctr_reg;
    assign last              = last_reg;

endmodule

`default_nettype wire
